// ===== rtl/core/vr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vr_pkg
// shared widths, constants and the arctangent table of the vector rotator
// ----------------------------------------------------------------------------
package vr_pkg;

    localparam int DATA_WIDTH   = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int ANGLE_BITS   = 16;

    localparam int ITERS   = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int CW      = 32;
    localparam int Q_SHIFT = 30;

    localparam int IN_TDATA_W  = ((2 * DATA_WIDTH + ANGLE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((2 * DATA_WIDTH + 7) / 8) * 8;

    localparam int PROD_W = DATA_WIDTH + CW;
    localparam int SUM_W  = PROD_W + 1;
    localparam int SH_W   = SUM_W - Q_SHIFT;

    localparam logic signed [CW-1:0] GAIN_INV = 32'sh26DD3B6A;

    localparam logic signed [CW-1:0] ATAN_TAB [32] = '{
        32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4,
        32'sh028B0D43, 32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55,
        32'sh0028BE53, 32'sh00145F2F, 32'sh000A2F98, 32'sh000517CC,
        32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA, 32'sh0000517D,
        32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
        32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051,
        32'sh00000029, 32'sh00000014, 32'sh0000000A, 32'sh00000005,
        32'sh00000003, 32'sh00000001, 32'sh00000001, 32'sh00000000
    };

    typedef logic signed [DATA_WIDTH-1:0] t_comp;
    typedef logic signed [CW-1:0]         t_word;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic signed [SH_W-1:0]       t_shifted;

endpackage

// ===== rtl/core/vector2_rotator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector2_rotator
// rotates a signed fixed-point 2d vector by a binary angle using a
// fully pipelined cordic, then rounds and saturates the products
// ----------------------------------------------------------------------------
// One item enters per clock cycle unless the pipeline holds; its result
// passes through one input stage that folds the angle to its nearest quarter
// turn, one stage per cordic iteration, one stage for the four component
// products and one output stage that rounds and saturates. The whole pipeline
// advances as one; it holds while the output item waits and the downstream
// side is not ready.
module vector2_rotator
    import vr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // vec_x, vec_y, turn_angle
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata   // rot_x, rot_y
);

    localparam int LAST = ITERS + 2;

    logic                   w_en;
    logic [LAST:0]          r_vld;

    t_comp                  r_vx   [0:ITERS];
    t_comp                  r_vy   [0:ITERS];
    logic [1:0]             r_quad [0:ITERS];
    t_word                  r_z    [0:ITERS];
    t_word                  r_cx   [0:ITERS];
    t_word                  r_cy   [0:ITERS];

    t_prod                  r_pxc, r_pys, r_pyc, r_pxs;
    t_comp                  r_rot_x, r_rot_y;

    logic [ANGLE_BITS-1:0]  w_angle;
    logic [1:0]             w_quad;
    logic [ANGLE_BITS-1:0]  w_resid;
    t_word                  w_c, w_s;
    logic signed [SUM_W-1:0] w_sum_x, w_sum_y;
    t_shifted               w_sh_x, w_sh_y;
    t_comp                  n_rot_x, n_rot_y;

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (Q_SHIFT - 1);

    function automatic t_comp sat(input t_shifted v);
        logic over_hi;
        logic over_lo;
        over_hi = !v[SH_W-1] && (|v[SH_W-2:DATA_WIDTH-1]);
        over_lo = v[SH_W-1] && !(&v[SH_W-2:DATA_WIDTH-1]);
        if (over_hi) begin
            sat = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end else if (over_lo) begin
            sat = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end else begin
            sat = v[DATA_WIDTH-1:0];
        end
    endfunction

    assign w_en          = !r_vld[LAST] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[LAST];
    assign m_axis_tdata  = OUT_TDATA_W'({r_rot_y, r_rot_x});

    // nearest quarter turn and residual angle
    assign w_angle = s_axis_tdata[2*DATA_WIDTH +: ANGLE_BITS];
    always_comb begin
        logic [ANGLE_BITS-1:0] biased;
        biased  = w_angle + ANGLE_BITS'(1 << (ANGLE_BITS - 3));
        w_quad  = biased[ANGLE_BITS-1 -: 2];
        w_resid = {w_angle[ANGLE_BITS-1 -: 2] - w_quad, w_angle[ANGLE_BITS-3:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAST-1:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_vx[0]   <= s_axis_tdata[0 +: DATA_WIDTH];
            r_vy[0]   <= s_axis_tdata[DATA_WIDTH +: DATA_WIDTH];
            r_quad[0] <= w_quad;
            r_z[0]    <= {w_resid, {(CW-ANGLE_BITS){1'b0}}};
            r_cx[0]   <= GAIN_INV;
            r_cy[0]   <= '0;
        end
    end

    // one cordic iteration per stage
    for (genvar gi = 0; gi < ITERS; gi++) begin : g_iter
        t_word w_dx, w_dy;
        assign w_dx = r_cy[gi] >>> gi;
        assign w_dy = r_cx[gi] >>> gi;
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_vx[gi+1]   <= r_vx[gi];
                r_vy[gi+1]   <= r_vy[gi];
                r_quad[gi+1] <= r_quad[gi];
                if (!r_z[gi][CW-1]) begin
                    r_cx[gi+1] <= r_cx[gi] - w_dx;
                    r_cy[gi+1] <= r_cy[gi] + w_dy;
                    r_z[gi+1]  <= r_z[gi] - ATAN_TAB[gi];
                end else begin
                    r_cx[gi+1] <= r_cx[gi] + w_dx;
                    r_cy[gi+1] <= r_cy[gi] - w_dy;
                    r_z[gi+1]  <= r_z[gi] + ATAN_TAB[gi];
                end
            end
        end
    end

    // quadrant applied by swap and negate
    always_comb begin
        case (r_quad[ITERS])
            2'd0: begin
                w_c = r_cx[ITERS];
                w_s = r_cy[ITERS];
            end
            2'd1: begin
                w_c = -r_cy[ITERS];
                w_s = r_cx[ITERS];
            end
            2'd2: begin
                w_c = -r_cx[ITERS];
                w_s = -r_cy[ITERS];
            end
            default: begin
                w_c = r_cy[ITERS];
                w_s = -r_cx[ITERS];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pxc <= PROD_W'(r_vx[ITERS]) * PROD_W'(w_c);
            r_pys <= PROD_W'(r_vy[ITERS]) * PROD_W'(w_s);
            r_pyc <= PROD_W'(r_vy[ITERS]) * PROD_W'(w_c);
            r_pxs <= PROD_W'(r_vx[ITERS]) * PROD_W'(w_s);
        end
    end

    // round half up and saturate
    always_comb begin
        w_sum_x = SUM_W'(r_pxc) - SUM_W'(r_pys) + ROUND_HALF;
        w_sum_y = SUM_W'(r_pyc) + SUM_W'(r_pxs) + ROUND_HALF;
        w_sh_x  = w_sum_x[SUM_W-1:Q_SHIFT];
        w_sh_y  = w_sum_y[SUM_W-1:Q_SHIFT];
        n_rot_x = sat(w_sh_x);
        n_rot_y = sat(w_sh_y);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rot_x <= n_rot_x;
            r_rot_y <= n_rot_y;
        end
    end

endmodule
